/* hdl/drm_pkg.sv */
// ---------------------------------------------------------------------------
// drm_pkg: shared definitions for the decimal exponent recurrence core.
// Value width, matrix type, register map and sequencer states.
// ---------------------------------------------------------------------------
package drm_pkg;

    // Width of every modular value.
    localparam int VALUE_WIDTH = 31;

    // Width of the bit counter inside the modular multiplier.
    localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

    // Width of one decimal digit and the power of ten taken per digit.
    localparam int DIGIT_WIDTH = 4;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = DIGIT_WIDTH'(10);

    // Configuration port geometry.
    localparam int ADDR_WIDTH = 5;
    localparam int DATA_WIDTH = 32;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    // A 2x2 matrix; entry index is {row, column}.
    typedef logic [3:0][VALUE_WIDTH-1:0] mat_t;

    // Register indexes, taken from paddr[4:2].
    typedef enum logic [2:0] {
        REG_START_FIRST  = 3'd0,
        REG_START_SECOND = 3'd1,
        REG_COEF_PREV    = 3'd2,
        REG_COEF_PREV2   = 3'd3,
        REG_MODULUS      = 3'd4
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_POW,
        ST_PROD,
        ST_FINAL,
        ST_EMIT
    } state_t;

endpackage

/* hdl/drm_mulmod.sv */
// ---------------------------------------------------------------------------
// drm_mulmod: bit-serial modular multiplier.
// Computes (a * b) mod m one bit of a per cycle, MSB first. Operand b must
// be below m; operand a may take any value.
// ---------------------------------------------------------------------------
module drm_mulmod (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start_i,
    input  drm_pkg::value_t     a_i,
    input  drm_pkg::value_t     b_i,
    input  drm_pkg::value_t     m_i,
    output logic                busy_o,
    output logic                done_o,
    output drm_pkg::value_t     result_o
);
    import drm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    value_t               a_reg, a_next;
    value_t               b_reg, b_next;
    value_t               m_reg, m_next;
    value_t               r_reg, r_next;

    logic [VALUE_WIDTH+1:0] t_sum;
    logic [VALUE_WIDTH+1:0] m_one;
    logic [VALUE_WIDTH+1:0] m_two;

    // One step: r = (2r + bit * b) mod m, the sum stays below 3m.
    always_comb begin
        m_one = {2'b00, m_reg};
        m_two = {1'b0, m_reg, 1'b0};
        t_sum = {1'b0, r_reg, 1'b0} + (a_reg[VALUE_WIDTH-1] ? {2'b00, b_reg} : '0);
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start_i) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a_i;
            b_next    = b_i;
            m_next    = m_i;
            r_next    = '0;
        end else if (busy_reg) begin
            priority if (t_sum >= m_two) begin
                r_next = VALUE_WIDTH'(t_sum - m_two);
            end else if (t_sum >= m_one) begin
                r_next = VALUE_WIDTH'(t_sum - m_one);
            end else begin
                r_next = VALUE_WIDTH'(t_sum);
            end
            a_next   = {a_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        r_reg   <= r_next;
    end

    assign busy_o   = busy_reg;
    assign done_o   = done_reg;
    assign result_o = r_reg;

    // A finished product is always reduced.
    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (r_reg < m_reg))
        else $error("mulmod result not below modulus");

    // A new operation is never started while one is running.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> !busy_reg)
        else $error("mulmod started while busy");

    // Completion is flagged exactly when the unit goes idle.
    a_done_on_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> done_reg)
        else $error("mulmod went idle without done");

endmodule

/* hdl/decimal_exponent_recurrence_mod_core.sv */
// ---------------------------------------------------------------------------
// decimal_exponent_recurrence_mod_core: term n of a 2x2 linear recurrence
// modulo m, with n taken as decimal digits, least significant first.
// Each modular multiply runs in the shared bit-serial multiplier; a digit d
// needs 8 * (max(d,10) + 1) multiplies (plus 2 on the first digit and 2 on
// the last digit).
// Throughput: one digit at a time; s_ready is high only between digits.
// Reset: synchronous, active low; only control and config registers reset.
// ---------------------------------------------------------------------------
module decimal_exponent_recurrence_mod_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [drm_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [drm_pkg::DATA_WIDTH-1:0]     pwdata,
    output logic [drm_pkg::DATA_WIDTH-1:0]     prdata,
    output logic                               pready,
    // Digit input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [drm_pkg::DIGIT_WIDTH-1:0]    s_digit,
    input  logic                               s_last_digit,
    // Term output
    output logic                               m_valid,
    input  logic                               m_ready,
    output drm_pkg::value_t                    m_term_value
);
    import drm_pkg::*;

    // Configuration registers.
    value_t start_first_reg, start_second_reg, coef_prev_reg, coef_prev2_reg, modulus_reg;
    reg_idx_t wr_idx;

    // Sequencer and datapath registers.
    state_t                 state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic                   issued_reg, issued_next;
    logic                   m_valid_reg, m_valid_next;
    value_t                 term_reg, term_next;
    logic [DIGIT_WIDTH-1:0] digit_reg, digit_next;
    logic                   last_reg, last_next;
    logic [DIGIT_WIDTH-1:0] pw_reg, pw_next;
    logic [2:0]             mix_reg, mix_next;
    value_t                 sum_reg, sum_next;
    mat_t                   q_reg, q_next;
    mat_t                   p_reg, p_next;
    mat_t                   acc_reg, acc_next;
    mat_t                   dpow_reg, dpow_next;
    mat_t                   ten_reg, ten_next;
    mat_t                   tmp_reg, tmp_next;

    // Multiplier interface.
    logic   mul_start, mul_busy, mul_done;
    value_t mul_a, mul_b, mul_res;

    // Derived values.
    value_t               m_eff;
    value_t               one_m;
    mat_t                 ident;
    logic [VALUE_WIDTH:0] add_full;
    value_t               add_mod;
    logic [1:0]           x_idx, y_idx;
    logic [DIGIT_WIDTH-1:0] pw_limit;
    mat_t                 mat_new;

    // Effective modulus: zero behaves as one.
    always_comb begin
        m_eff = (modulus_reg == '0) ? VALUE_WIDTH'(1) : modulus_reg;
        one_m = (m_eff == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
        ident = {one_m, value_t'('0), value_t'('0), one_m};
        add_full = {1'b0, sum_reg} + {1'b0, mul_res};
        add_mod  = (add_full >= {1'b0, m_eff}) ?
                   VALUE_WIDTH'(add_full - {1'b0, m_eff}) : VALUE_WIDTH'(add_full);
        // Entry {i,k} = mix[2:1], term j = mix[0].
        x_idx    = {mix_reg[2], mix_reg[0]};
        y_idx    = {mix_reg[0], mix_reg[1]};
        pw_limit = (digit_reg > DIGIT_TEN) ? digit_reg : DIGIT_TEN;
        mat_new  = tmp_reg;
        mat_new[mix_reg[2:1]] = add_mod;
    end

    // APB writes and reads.
    assign pready = 1'b1;
    assign wr_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_first_reg  <= '0;
            start_second_reg <= '0;
            coef_prev_reg    <= '0;
            coef_prev2_reg   <= '0;
            modulus_reg      <= VALUE_WIDTH'(1);
        end else if (psel && penable && pwrite) begin
            unique case (wr_idx)
                REG_START_FIRST:  start_first_reg  <= pwdata[VALUE_WIDTH-1:0];
                REG_START_SECOND: start_second_reg <= pwdata[VALUE_WIDTH-1:0];
                REG_COEF_PREV:    coef_prev_reg    <= pwdata[VALUE_WIDTH-1:0];
                REG_COEF_PREV2:   coef_prev2_reg   <= pwdata[VALUE_WIDTH-1:0];
                REG_MODULUS:      modulus_reg      <= pwdata[VALUE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (wr_idx)
            REG_START_FIRST:  prdata = DATA_WIDTH'(start_first_reg);
            REG_START_SECOND: prdata = DATA_WIDTH'(start_second_reg);
            REG_COEF_PREV:    prdata = DATA_WIDTH'(coef_prev_reg);
            REG_COEF_PREV2:   prdata = DATA_WIDTH'(coef_prev2_reg);
            REG_MODULUS:      prdata = DATA_WIDTH'(modulus_reg);
            default:          prdata = '0;
        endcase
    end

    // Shared modular multiplier.
    drm_mulmod u_mulmod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start_i  (mul_start),
        .a_i      (mul_a),
        .b_i      (mul_b),
        .m_i      (m_eff),
        .busy_o   (mul_busy),
        .done_o   (mul_done),
        .result_o (mul_res)
    );

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        issued_next  = issued_reg;
        m_valid_next = m_valid_reg;
        term_next    = term_reg;
        digit_next   = digit_reg;
        last_next    = last_reg;
        pw_next      = pw_reg;
        mix_next     = mix_reg;
        sum_next     = sum_reg;
        q_next       = q_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        dpow_next    = dpow_reg;
        ten_next     = ten_reg;
        tmp_next     = tmp_reg;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;

        // The output transaction completes.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Issue one multiply per step in any arithmetic state.
        if ((state_reg == ST_BUILD || state_reg == ST_POW || state_reg == ST_PROD ||
             state_reg == ST_FINAL) && !issued_reg && !mul_busy) begin
            mul_start   = 1'b1;
            issued_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    digit_next = s_digit;
                    last_next  = s_last_digit;
                    acc_next   = ident;
                    dpow_next  = ident;
                    ten_next   = ident;
                    pw_next    = DIGIT_WIDTH'(1);
                    mix_next   = '0;
                    if (!busy_reg) begin
                        p_next     = ident;
                        busy_next  = 1'b1;
                        state_next = ST_BUILD;
                    end else begin
                        state_next = ST_POW;
                    end
                end
            end
            // Reduce the coefficients into the step matrix.
            ST_BUILD: begin
                mul_a = mix_reg[0] ? coef_prev_reg : coef_prev2_reg;
                mul_b = one_m;
                if (mul_done) begin
                    issued_next = 1'b0;
                    if (mix_reg[0]) begin
                        q_next[3]  = mul_res;
                        q_next[1]  = one_m;
                        q_next[0]  = '0;
                        mix_next   = '0;
                        state_next = ST_POW;
                    end else begin
                        q_next[2] = mul_res;
                        mix_next  = 3'd1;
                    end
                end
            end
            // acc = acc * Q, capturing Q^d and Q^10 on the way.
            ST_POW: begin
                mul_a = acc_reg[x_idx];
                mul_b = q_reg[y_idx];
                if (mul_done) begin
                    issued_next = 1'b0;
                    if (!mix_reg[0]) begin
                        sum_next = mul_res;
                        mix_next = mix_reg + 3'd1;
                    end else if (mix_reg != 3'd7) begin
                        tmp_next[mix_reg[2:1]] = add_mod;
                        mix_next = mix_reg + 3'd1;
                    end else begin
                        acc_next = mat_new;
                        if (pw_reg == digit_reg) begin
                            dpow_next = mat_new;
                        end
                        if (pw_reg == DIGIT_TEN) begin
                            ten_next = mat_new;
                        end
                        mix_next = '0;
                        if (pw_reg >= pw_limit) begin
                            state_next = ST_PROD;
                        end else begin
                            pw_next = pw_reg + 1'b1;
                        end
                    end
                end
            end
            // P = P * Q^d, then Q becomes Q^10.
            ST_PROD: begin
                mul_a = p_reg[x_idx];
                mul_b = dpow_reg[y_idx];
                if (mul_done) begin
                    issued_next = 1'b0;
                    if (!mix_reg[0]) begin
                        sum_next = mul_res;
                        mix_next = mix_reg + 3'd1;
                    end else if (mix_reg != 3'd7) begin
                        tmp_next[mix_reg[2:1]] = add_mod;
                        mix_next = mix_reg + 3'd1;
                    end else begin
                        p_next     = mat_new;
                        q_next     = ten_reg;
                        mix_next   = '0;
                        state_next = last_reg ? ST_FINAL : ST_IDLE;
                    end
                end
            end
            // term = P00 * x0 + P01 * x1.
            ST_FINAL: begin
                mul_a = mix_reg[0] ? start_second_reg : start_first_reg;
                mul_b = mix_reg[0] ? p_reg[1] : p_reg[0];
                if (mul_done) begin
                    issued_next = 1'b0;
                    if (!mix_reg[0]) begin
                        sum_next = mul_res;
                        mix_next = 3'd1;
                    end else begin
                        sum_next   = add_mod;
                        p_next     = ident;
                        busy_next  = 1'b0;
                        mix_next   = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            // Hand the term to the output register once it is free.
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    term_next    = sum_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
        term_reg  <= term_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
        pw_reg    <= pw_next;
        mix_reg   <= mix_next;
        sum_reg   <= sum_next;
        q_reg     <= q_next;
        p_reg     <= p_next;
        acc_reg   <= acc_next;
        dpow_reg  <= dpow_next;
        ten_reg   <= ten_next;
        tmp_reg   <= tmp_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_term_value = term_reg;

    // A waiting term transaction holds its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_term_value)))
        else $error("term changed while waiting");

    // The shared multiplier is only started when it is idle.
    a_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiply issued while busy");

    // A running multiply always belongs to an issued step.
    a_busy_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_busy |-> issued_reg)
        else $error("multiplier busy without an issued step");

endmodule

/* tb/sv/tb_decimal_exponent_recurrence_mod_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for decimal_exponent_recurrence_mod_core
// Feeds decimal index digits and checks each emitted term against a
// behavioral matrix-power predictor. It runs several register settings and
// several sender and receiver stall patterns.
// ---------------------------------------------------------------------------
module tb_decimal_exponent_recurrence_mod_core;
    import drm_pkg::*;

    typedef longint unsigned u64_t;

    // Term predictor and store of expected terms.
    class term_scoreboard;
        u64_t regs [5];
        u64_t prod [4];
        u64_t pw [4];
        bit   busy;
        u64_t term_q [$];
        int   mismatches;

        function new();
            regs = '{0, 0, 0, 0, 1};
            prod = '{1, 0, 0, 1};
            pw = '{0, 1, 0, 0};
            busy = 0;
            mismatches = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] val);
            regs[idx] = u64_t'(val[VALUE_WIDTH-1:0]);
        endfunction

        function u64_t eff_mod();
            return (regs[REG_MODULUS] == 0) ? 1 : regs[REG_MODULUS];
        endfunction

        // 2x2 modular product; entry index is 2*row + column.
        function void mat_mul(input u64_t x [4], input u64_t y [4], input u64_t m,
                              output u64_t r [4]);
            u64_t s;
            for (int i = 0; i < 2; i++) begin
                for (int k = 0; k < 2; k++) begin
                    s = 0;
                    for (int j = 0; j < 2; j++)
                        s = (s + (x[2*i+j] % m) * (y[2*j+k] % m) % m) % m;
                    r[2*i+k] = s;
                end
            end
        endfunction

        // Accepted digit transaction: advance the matrices, queue a term on last.
        function void note_digit(logic [3:0] d, logic last);
            u64_t m, t0, t1;
            u64_t acc [4];
            u64_t dpow [4];
            u64_t tenpow [4];
            u64_t tmp [4];
            m = eff_mod();
            if (!busy) begin
                prod = '{1, 0, 0, 1};
                pw = '{0, 1 % m, regs[REG_COEF_PREV2] % m, regs[REG_COEF_PREV] % m};
                busy = 1;
            end
            acc = '{1, 0, 0, 1};
            dpow = acc;
            tenpow = acc;
            for (int j = 1; j <= 15; j++) begin
                mat_mul(acc, pw, m, tmp);
                acc = tmp;
                if (j == d) dpow = acc;
                if (j == 10) tenpow = acc;
            end
            mat_mul(prod, dpow, m, tmp);
            prod = tmp;
            pw = tenpow;
            if (last) begin
                t0 = prod[0] % m * (regs[REG_START_FIRST] % m) % m;
                t1 = prod[1] % m * (regs[REG_START_SECOND] % m) % m;
                term_q.push_back((t0 + t1) % m);
                prod = '{1, 0, 0, 1};
                busy = 0;
            end
        endfunction

        // Accepted term transaction: compare with the oldest expected term.
        function void check_term(value_t got);
            u64_t want;
            if (term_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected term transaction: got %0d", got);
                return;
            end
            want = term_q.pop_front();
            if (u64_t'(got) != want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Term mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  psel, penable, pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  s_valid, s_ready;
    logic [DIGIT_WIDTH-1:0] s_digit;
    logic                  s_last_digit;
    logic                  m_valid, m_ready;
    value_t                m_term_value;

    term_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    decimal_exponent_recurrence_mod_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_digit(s_digit),
        .s_last_digit(s_last_digit),
        .m_valid(m_valid), .m_ready(m_ready), .m_term_value(m_term_value)
    );

    // Clock generation.
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls and term checking.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_term(m_term_value);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Register write over the configuration port while the core is idle.
    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_WIDTH'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic load_regs(logic [31:0] x0, logic [31:0] x1, logic [31:0] a,
                             logic [31:0] b, logic [31:0] m);
        write_reg(REG_START_FIRST, x0);
        write_reg(REG_START_SECOND, x1);
        write_reg(REG_COEF_PREV, a);
        write_reg(REG_COEF_PREV2, b);
        write_reg(REG_MODULUS, m);
    endtask

    // One digit transaction; valid is lowered only when a gap is taken.
    task automatic send_digit(logic [3:0] d, logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < 60);
        end
        s_valid <= 1;
        s_digit <= d;
        s_last_digit <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_digit(d, last);
    endtask

    // A whole index with random digits, mostly 1 to 4 digits long.
    task automatic send_index(output int count);
        int len;
        logic [3:0] d;
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 5) : $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
            d = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                         : 4'($urandom_range(9));
            send_digit(d, i == len - 1);
        end
        count = len;
    endtask

    // Let the core drain before touching registers.
    task automatic drain();
        s_valid <= 0;
        while (sb.term_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Stimulus.
    initial begin
        int n, phase_items;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_valid = 0; s_digit = '0; s_last_digit = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset registers, then extremes and special cases.
        send_digit(4'd5, 1'b1);
        drain();
        load_regs(32'd0, 32'd1, 32'd1, 32'd1, 32'd1000000007);
        send_digit(4'd0, 1'b1);
        send_digit(4'd9, 1'b1);
        send_digit(4'd0, 1'b0);
        send_digit(4'd1, 1'b1);
        send_digit(4'd15, 1'b0);
        send_digit(4'd12, 1'b1);
        drain();
        load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF);
        send_digit(4'd9, 1'b0);
        send_digit(4'd9, 1'b1);
        send_digit(4'd15, 1'b1);
        drain();
        // Modulus zero acts as one; operands above the modulus get reduced.
        load_regs(32'd5, 32'd7, 32'd3, 32'd2, 32'h8000_0000);
        send_digit(4'd3, 1'b1);
        drain();
        load_regs(32'd123456, 32'd654321, 32'd99999, 32'd77777, 32'd13);
        send_digit(4'd7, 1'b0);
        send_digit(4'd0, 1'b0);
        send_digit(4'd2, 1'b1);
        drain();
        load_regs(32'd1, 32'd2, 32'd1, 32'd0, 32'd2);
        send_digit(4'd1, 1'b1);
        send_digit(4'd10, 1'b1);
        drain();

        // Random phases with different stall patterns and settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 1)
                load_regs($urandom, $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
            else if (ph == 3)
                load_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(50, 1));
            else
                load_regs($urandom, $urandom, $urandom, $urandom, $urandom);
            phase_items = 0;
            while (phase_items < 410) begin
                send_index(n);
                phase_items += n;
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.term_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial begin
        #200ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
